### rtl/vhcs_pkg.sv
// Package for the viewport hit and coordinate scaler.
// Holds table sizes, opcodes, field codes and the controller/datapath command types.
`default_nettype none
package vhcs_pkg;
	localparam int TableDepth = 256;
	localparam int DefaultEntries = 32;
	localparam int IdxW = 8;
	localparam int CntW = 10;
	localparam int DivW = 34;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FWD = 2'd1;
	localparam logic [1:0] OP_INV = 2'd2;

	localparam logic [2:0] FLD_PRESENT = 3'd0;
	localparam logic [2:0] FLD_ORG_X = 3'd1;
	localparam logic [2:0] FLD_ORG_Y = 3'd2;
	localparam logic [2:0] FLD_VIEW_W = 3'd3;
	localparam logic [2:0] FLD_VIEW_H = 3'd4;
	localparam logic [2:0] FLD_TGT_W = 3'd5;
	localparam logic [2:0] FLD_TGT_H = 3'd6;
	localparam logic [2:0] FLD_ENABLED = 3'd7;

	typedef struct packed {
		logic load;
		logic write;
		logic rd;
		logic check;
		logic div_start;
		logic div_y;
		logic finish;
		logic miss;
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic hit;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

### rtl/vhcs_ctrl.sv
// Controller state machine for the viewport scaler.
// Uses vhcs_pkg command and status types.
`default_nettype none
module vhcs_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic out_ready,
	output logic out_valid,
	output vhcs_pkg::cmd_t cmd,
	input wire vhcs_pkg::sts_t sts
);
	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_WAIT, S_CHECK, S_DIVX_GO, S_DIVX, S_DIVY_GO, S_DIVY,
		S_DONE
	} state_t;
	state_t state_q;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid && in_ready;
				cmd.write = in_valid && in_ready && (op == vhcs_pkg::OP_WRITE);
				cmd.miss = in_valid && in_ready && (op != vhcs_pkg::OP_FWD) &&
					(op != vhcs_pkg::OP_INV);
			end
			S_READ: cmd.rd = !sts.scan_end;
			S_WAIT: ;
			S_CHECK: begin
				cmd.check = 1'b1;
				cmd.miss = sts.scan_end;
			end
			S_DIVX_GO: cmd.div_start = 1'b1;
			S_DIVX: ;
			S_DIVY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_y = 1'b1;
			end
			S_DIVY: cmd.div_y = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					if (op == vhcs_pkg::OP_FWD || op == vhcs_pkg::OP_INV) begin
						state_q <= S_READ;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				S_READ: begin
					if (sts.scan_end) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.hit) state_q <= S_DIVX_GO;
					else state_q <= S_READ;
				end
				S_DIVX_GO: state_q <= S_DIVX;
				S_DIVX: if (sts.div_done) state_q <= S_DIVY_GO;
				S_DIVY_GO: state_q <= S_DIVY;
				S_DIVY: if (sts.div_done) state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q)
		else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready)
		else $error("accepted while busy");
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> out_valid_q)
		else $error("finished without result");
`endif
endmodule
`default_nettype wire

### rtl/vhcs_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Uses vhcs_pkg widths.
`default_nettype none
module vhcs_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [vhcs_pkg::DivW-1:0] num,
	input wire logic [15:0] den,
	output logic done,
	output logic signed [vhcs_pkg::DivW-1:0] quot
);
	localparam int W = vhcs_pkg::DivW;
	logic [W-1:0] q_q;
	logic [16:0] r_q;
	logic [5:0] cnt_q;
	logic busy_q, neg_q;
	logic [16:0] trial;
	logic [16:0] diff;

	assign trial = {r_q[15:0], q_q[W-1]};
	assign diff = trial - {1'b0, den};
	assign done = busy_q && (cnt_q == 6'd0);
	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(W);
		end else if (busy_q && cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[W-1];
			q_q <= num[W-1] ? W'(-num) : W'(num);
			r_q <= '0;
		end else if (busy_q && cnt_q != 6'd0) begin
			if (!diff[16]) begin
				r_q <= diff;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

### rtl/vhcs_dp.sv
// Datapath: entry table memory, scan counter, hit test and scaling arithmetic.
// Uses vhcs_pkg and the vhcs_div unit.
`default_nettype none
module vhcs_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire vhcs_pkg::cmd_t cmd,
	output vhcs_pkg::sts_t sts,
	input wire logic cfg_we,
	input wire logic cfg_sel,
	input wire logic [9:0] cfg_data,
	input wire logic [1:0] op,
	input wire logic [7:0] entry_index,
	input wire logic [2:0] field_select,
	input wire logic signed [15:0] field_value,
	input wire logic signed [15:0] cursor_x,
	input wire logic signed [15:0] cursor_y,
	input wire logic signed [15:0] client_x,
	input wire logic signed [15:0] client_y,
	output logic hit,
	output logic [7:0] hit_index,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y
);
	localparam int D = vhcs_pkg::TableDepth;
	localparam int W = vhcs_pkg::DivW;

	logic [D-1:0] present_q, enabled_q;
	logic signed [15:0] mem_ox [D], mem_oy [D], mem_vw [D], mem_vh [D];
	logic signed [15:0] mem_tw [D], mem_th [D];
	logic [9:0] max_q, count_q;
	logic [9:0] lim, scan_len;
	logic [9:0] ptr_q;
	logic [1:0] op_q;
	logic signed [15:0] cx_q, cy_q, kx_q, ky_q;
	logic signed [15:0] ox_q, oy_q, vw_q, vh_q, tw_q, th_q;
	logic ok_q;
	logic [7:0] idx_q;
	logic signed [W-1:0] num_s1;
	logic [15:0] den;
	logic div_done;
	logic signed [W-1:0] quot;
	logic signed [16:0] dx, dy;
	logic signed [16:0] ex, ey;
	logic inside_hit;

	always_comb begin
		lim = (max_q == '0) ? 10'(vhcs_pkg::DefaultEntries) : max_q;
		if (lim > 10'(D)) lim = 10'(D);
		scan_len = (count_q == '0 || count_q > lim) ? lim : count_q;
	end

	assign ex = 17'(ox_q) + 17'(vw_q);
	assign ey = 17'(oy_q) + 17'(vh_q);
	assign inside_hit = ok_q && vw_q > 0 && vh_q > 0 && tw_q > 0 && th_q > 0 &&
		cx_q >= ox_q && 17'(cx_q) < ex && cy_q >= oy_q && 17'(cy_q) < ey;

	assign sts.scan_end = (ptr_q >= scan_len);
	assign sts.hit = inside_hit;
	assign sts.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			enabled_q <= '0;
			max_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_we && !cfg_sel) max_q <= cfg_data;
			if (cfg_we && cfg_sel) count_q <= cfg_data;
			if (cmd.write && field_select == vhcs_pkg::FLD_PRESENT)
				present_q[entry_index] <= (field_value != 0);
			if (cmd.write && field_select == vhcs_pkg::FLD_ENABLED)
				enabled_q[entry_index] <= (field_value != 0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			unique case (field_select)
				vhcs_pkg::FLD_ORG_X: mem_ox[entry_index] <= field_value;
				vhcs_pkg::FLD_ORG_Y: mem_oy[entry_index] <= field_value;
				vhcs_pkg::FLD_VIEW_W: mem_vw[entry_index] <= field_value;
				vhcs_pkg::FLD_VIEW_H: mem_vh[entry_index] <= field_value;
				vhcs_pkg::FLD_TGT_W: mem_tw[entry_index] <= field_value;
				vhcs_pkg::FLD_TGT_H: mem_th[entry_index] <= field_value;
				default: ;
			endcase
		end
		if (cmd.rd) begin
			ox_q <= mem_ox[ptr_q[7:0]];
			oy_q <= mem_oy[ptr_q[7:0]];
			vw_q <= mem_vw[ptr_q[7:0]];
			vh_q <= mem_vh[ptr_q[7:0]];
			tw_q <= mem_tw[ptr_q[7:0]];
			th_q <= mem_th[ptr_q[7:0]];
			ok_q <= present_q[ptr_q[7:0]] && enabled_q[ptr_q[7:0]];
			idx_q <= ptr_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.load) begin
			ptr_q <= '0;
		end else if (cmd.rd) begin
			ptr_q <= ptr_q + 10'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op;
			cx_q <= cursor_x;
			cy_q <= cursor_y;
			kx_q <= client_x;
			ky_q <= client_y;
		end
	end

	assign dx = 17'(cx_q) - 17'(ox_q);
	assign dy = 17'(cy_q) - 17'(oy_q);

	// Numerator for the axis in work, registered ahead of the divider.
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			if (op_q == vhcs_pkg::OP_FWD) num_s1 <= W'(dx * tw_q) + W'(vw_q >>> 1);
			else num_s1 <= W'(kx_q * vw_q) + W'(tw_q >>> 1);
		end else if (div_done && !cmd.div_y) begin
			if (op_q == vhcs_pkg::OP_FWD) num_s1 <= W'(dy * th_q) + W'(vh_q >>> 1);
			else num_s1 <= W'(ky_q * vh_q) + W'(th_q >>> 1);
		end
	end

	assign den = (op_q == vhcs_pkg::OP_FWD) ? (cmd.div_y ? vh_q : vw_q) :
		(cmd.div_y ? th_q : tw_q);

	vhcs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num_s1), .den(den), .done(div_done), .quot(quot)
	);

	function automatic logic signed [31:0] post(input logic fwd,
		input logic signed [W-1:0] q, input logic signed [15:0] tsz,
		input logic signed [15:0] org);
		logic signed [W-1:0] r;
		r = q;
		if (fwd) begin
			if (r < 0) r = '0;
			if (r >= W'(tsz)) r = W'(tsz) - 1;
		end else begin
			r = r + W'(org);
		end
		return r[31:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.miss) begin
			hit <= 1'b0;
			hit_index <= '0;
			out_x <= '0;
			out_y <= '0;
		end else begin
			if (div_done && !cmd.div_y)
				out_x <= post(op_q == vhcs_pkg::OP_FWD, quot, tw_q, ox_q);
			if (div_done && cmd.div_y)
				out_y <= post(op_q == vhcs_pkg::OP_FWD, quot, th_q, oy_q);
			if (cmd.finish) begin
				hit <= 1'b1;
				hit_index <= idx_q;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/viewport_hit_and_coordinate_scaler.sv
// Top level of the viewport hit and coordinate scaler.
// Uses vhcs_pkg, vhcs_ctrl and vhcs_dp.
//
// One input channel (in_valid/in_ready) takes write, forward and inverse items.
// Each item gives one result on the output channel (out_valid/out_ready).
// A configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// entry limit (index 0) and the scan count (index 1); it is always ready.
// A write item's result is registered, valid in the cycle after its transfer, so writes can
// follow one per cycle while the receiver is ready. A lookup reads the entries one
// at a time through the table's single read port, passing through the read, wait
// and check states for each entry. A hit then runs two 34-step serial divisions.
// Reset clears the present and enabled flags and both registers at once;
// no clearing pass is needed. A held result stays on the output while the
// receiver stalls, and the next item is taken in the cycle of its transfer.
`default_nettype none
module viewport_hit_and_coordinate_scaler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] op,
	input wire logic [7:0] entry_index,
	input wire logic [2:0] field_select,
	input wire logic signed [15:0] field_value,
	input wire logic signed [15:0] cursor_x,
	input wire logic signed [15:0] cursor_y,
	input wire logic signed [15:0] client_x,
	input wire logic signed [15:0] client_y,
	output logic out_valid,
	input wire logic out_ready,
	output logic hit,
	output logic [7:0] hit_index,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [9:0] cfg_data
);
	vhcs_pkg::cmd_t cmd;
	vhcs_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	vhcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .out_ready(out_ready), .out_valid(out_valid), .cmd(cmd), .sts(sts)
	);

	vhcs_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid), .cfg_sel(cfg_index[0]), .cfg_data(cfg_data),
		.op(op), .entry_index(entry_index), .field_select(field_select),
		.field_value(field_value), .cursor_x(cursor_x), .cursor_y(cursor_y),
		.client_x(client_x), .client_y(client_y), .hit(hit), .hit_index(hit_index),
		.out_x(out_x), .out_y(out_y)
	);
endmodule
`default_nettype wire

### test/viewport_scaler_checker.sv
// Checker for the viewport hit and coordinate scaler: watches the input, output and
// configuration channels, predicts each result and compares it. Depends on vhcs_pkg.
`timescale 1ns / 100ps
module viewport_scaler_checker
	import vhcs_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [1:0] op,
	input wire logic [7:0] entry_index,
	input wire logic [2:0] field_select,
	input wire logic signed [15:0] field_value,
	input wire logic signed [15:0] cursor_x,
	input wire logic signed [15:0] cursor_y,
	input wire logic signed [15:0] client_x,
	input wire logic signed [15:0] client_y,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic hit,
	input wire logic [7:0] hit_index,
	input wire logic signed [31:0] out_x,
	input wire logic signed [31:0] out_y,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [9:0] cfg_data,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic hit;
		logic [7:0] idx;
		logic [31:0] x;
		logic [31:0] y;
	} point_result_t;

	logic [9:0] limit_reg;
	logic [9:0] count_reg;
	logic present_q [TableDepth];
	logic enabled_q [TableDepth];
	logic signed [15:0] org_x_q [TableDepth];
	logic signed [15:0] org_y_q [TableDepth];
	logic signed [15:0] view_w_q [TableDepth];
	logic signed [15:0] view_h_q [TableDepth];
	logic signed [15:0] tgt_w_q [TableDepth];
	logic signed [15:0] tgt_h_q [TableDepth];
	point_result_t expected_points[$];

	assign pending = expected_points.size();

	function automatic int scan_entries();
		int lim;
		int n;
		lim = (limit_reg == 0) ? DefaultEntries : int'(limit_reg);
		if (lim > TableDepth) lim = TableDepth;
		n = int'(count_reg);
		if (n == 0 || n > lim) n = lim;
		return n;
	endfunction

	function automatic point_result_t map_point(input logic [1:0] o,
		input int px, input int py, input int kx, input int ky);
		point_result_t r;
		longint vw, vh, cw, ch, rx, ry;
		int n;
		int found;
		r = '0;
		if (o != OP_FWD && o != OP_INV) return r;
		found = -1;
		n = scan_entries();
		for (int i = 0; i < n; i++) begin
			if (found < 0 && present_q[i] && enabled_q[i] && view_w_q[i] > 0 &&
					view_h_q[i] > 0 && tgt_w_q[i] > 0 && tgt_h_q[i] > 0 &&
					px >= org_x_q[i] && px < org_x_q[i] + view_w_q[i] &&
					py >= org_y_q[i] && py < org_y_q[i] + view_h_q[i])
				found = i;
		end
		if (found < 0) return r;
		vw = view_w_q[found];
		vh = view_h_q[found];
		cw = tgt_w_q[found];
		ch = tgt_h_q[found];
		if (o == OP_FWD) begin
			rx = ((longint'(px) - org_x_q[found]) * cw + vw / 2) / vw;
			ry = ((longint'(py) - org_y_q[found]) * ch + vh / 2) / vh;
			if (rx < 0) rx = 0;
			if (ry < 0) ry = 0;
			if (rx >= cw) rx = cw - 1;
			if (ry >= ch) ry = ch - 1;
		end else begin
			rx = org_x_q[found] + (longint'(kx) * vw + cw / 2) / cw;
			ry = org_y_q[found] + (longint'(ky) * vh + ch / 2) / ch;
		end
		r.hit = 1'b1;
		r.idx = found[7:0];
		r.x = rx[31:0];
		r.y = ry[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_result_t exp_r;
		if (!arst_n) begin
			limit_reg <= '0;
			count_reg <= '0;
			for (int i = 0; i < TableDepth; i++) begin
				present_q[i] <= 1'b0;
				enabled_q[i] <= 1'b0;
			end
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == 1'b0) limit_reg <= cfg_data;
				else count_reg <= cfg_data;
			end
			if (in_valid && in_ready) begin
				if (op == OP_WRITE) begin
					case (field_select)
						FLD_PRESENT: present_q[entry_index] <= (field_value != 0);
						FLD_ORG_X: org_x_q[entry_index] <= field_value;
						FLD_ORG_Y: org_y_q[entry_index] <= field_value;
						FLD_VIEW_W: view_w_q[entry_index] <= field_value;
						FLD_VIEW_H: view_h_q[entry_index] <= field_value;
						FLD_TGT_W: tgt_w_q[entry_index] <= field_value;
						FLD_TGT_H: tgt_h_q[entry_index] <= field_value;
						default: enabled_q[entry_index] <= (field_value != 0);
					endcase
					expected_points.push_back('0);
				end else begin
					expected_points.push_back(map_point(op, cursor_x, cursor_y,
						client_x, client_y));
				end
			end
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result transfer with nothing expected", $realtime);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_points.pop_front();
					if (hit !== exp_r.hit || hit_index !== exp_r.idx ||
							out_x !== exp_r.x || out_y !== exp_r.y) begin
						if (fail_count < 10)
							$display("%0t: expected hit=%0b idx=%0d x=%0d y=%0d, got hit=%0b idx=%0d x=%0d y=%0d",
								$realtime, exp_r.hit, exp_r.idx, $signed(exp_r.x),
								$signed(exp_r.y), hit, hit_index, out_x, out_y);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

### test/testbench.sv
// Top of the viewport hit and coordinate scaler testbench: clock, reset, stimulus and verdict.
// Depends on vhcs_pkg, the block itself and viewport_scaler_checker.
`timescale 1ns / 100ps
module testbench;
	import vhcs_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] op;
	logic [7:0] entry_index;
	logic [2:0] field_select;
	logic signed [15:0] field_value;
	logic signed [15:0] cursor_x;
	logic signed [15:0] cursor_y;
	logic signed [15:0] client_x;
	logic signed [15:0] client_y;
	logic out_valid;
	logic out_ready;
	logic hit;
	logic [7:0] hit_index;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [9:0] cfg_data;
	int fail_count;
	int pending;

	logic hold_req;
	logic no_idle;
	int sent;
	logic [5:0] fields_written [TableDepth];
	int geo_x [TableDepth];
	int geo_y [TableDepth];
	int geo_w [TableDepth];
	int geo_h [TableDepth];
	int mapped[$];

	viewport_hit_and_coordinate_scaler u_dut (.*);

	viewport_scaler_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
				hold_req = 1'b0;
			end else if (no_idle || $urandom_range(0, 99) < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 80)) @(negedge clk);
				else repeat ($urandom_range(0, 3)) @(negedge clk);
			end
		end
	end

	task automatic send(input logic [1:0] o, input logic [7:0] e, input logic [2:0] f,
		input logic [15:0] v, input logic [15:0] cx, input logic [15:0] cy,
		input logic [15:0] kx, input logic [15:0] ky);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		gap = (no_idle || r < 55) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(10, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		entry_index <= e;
		field_select <= f;
		field_value <= v;
		cursor_x <= cx;
		cursor_y <= cy;
		client_x <= kx;
		client_y <= ky;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	// Flags are only raised on entries whose six geometry fields have all been written.
	task automatic write_field(input logic [7:0] e, input logic [2:0] f, input logic [15:0] v);
		logic [15:0] val;
		val = v;
		if ((f == FLD_PRESENT || f == FLD_ENABLED) && fields_written[e] != 6'h3f) val = '0;
		if (f != FLD_PRESENT && f != FLD_ENABLED) fields_written[e][f - 1] = 1'b1;
		case (f)
			FLD_ORG_X: geo_x[e] = $signed(val);
			FLD_ORG_Y: geo_y[e] = $signed(val);
			FLD_VIEW_W: geo_w[e] = $signed(val);
			FLD_VIEW_H: geo_h[e] = $signed(val);
			default: ;
		endcase
		send(OP_WRITE, e, f, val, rnd16(), rnd16(), rnd16(), rnd16());
	endtask

	function automatic logic [15:0] nonzero16();
		return rnd16() | (16'd1 << $urandom_range(0, 15));
	endfunction

	function automatic logic [15:0] size16();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return 16'($urandom_range(1, 400));
		if (r < 88) return 16'($urandom_range(1, 32767));
		if (r < 94) return '0;
		return rnd16() | 16'h8000;
	endfunction

	task automatic program_entry(input logic [7:0] e, input logic wide);
		logic [15:0] ox, oy;
		ox = wide ? rnd16() : 16'($urandom_range(0, 600) - 300);
		oy = wide ? rnd16() : 16'($urandom_range(0, 600) - 300);
		write_field(e, FLD_ORG_X, ox);
		write_field(e, FLD_ORG_Y, oy);
		write_field(e, FLD_VIEW_W, size16());
		write_field(e, FLD_VIEW_H, size16());
		write_field(e, FLD_TGT_W, size16());
		write_field(e, FLD_TGT_H, size16());
		write_field(e, FLD_PRESENT, nonzero16());
		write_field(e, FLD_ENABLED, nonzero16());
		mapped.push_back(e);
	endtask

	task automatic lookup(input logic [1:0] o, input logic aimed);
		int e;
		logic [15:0] cx, cy;
		cx = rnd16();
		cy = rnd16();
		if (aimed && mapped.size() > 0) begin
			e = mapped[$urandom_range(0, mapped.size() - 1)];
			cx = 16'(geo_x[e] + ((geo_w[e] > 0) ? $urandom_range(0, geo_w[e] - 1) : 0)
				+ (($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) - 1 : 0));
			cy = 16'(geo_y[e] + ((geo_h[e] > 0) ? $urandom_range(0, geo_h[e] - 1) : 0)
				+ (($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) - 1 : 0));
		end
		send(o, 8'($urandom), 3'($urandom), rnd16(), cx, cy, rnd16(), rnd16());
	endtask

	task automatic configure(input logic [9:0] lim, input logic [9:0] cnt);
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[0:0];
			cfg_data <= (i == 0) ? lim : cnt;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		logic [9:0] limits [8];
		logic [9:0] counts [8];
		int r;
		limits = '{10'd0, 10'd1023, 10'd0, 10'd256, 10'd1, 10'd300, 10'd5, 10'd1023};
		counts = '{10'd0, 10'd0, 10'd5, 10'd1023, 10'd0, 10'd200, 10'd3, 10'd1023};
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_WRITE;
		entry_index = '0;
		field_select = '0;
		field_value = '0;
		cursor_x = '0;
		cursor_y = '0;
		client_x = '0;
		client_y = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		no_idle = 1'b0;
		sent = 0;
		for (int i = 0; i < TableDepth; i++) fields_written[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: one known viewport, its corners, a miss, the unused opcode, extremes.
		send(OP_FWD, 8'd0, FLD_PRESENT, '0, 16'sd0, 16'sd0, '0, '0);
		write_field(8'd0, FLD_ORG_X, 16'sd10);
		write_field(8'd0, FLD_ORG_Y, 16'sd20);
		write_field(8'd0, FLD_VIEW_W, 16'sd100);
		write_field(8'd0, FLD_VIEW_H, 16'sd50);
		write_field(8'd0, FLD_TGT_W, 16'sd640);
		write_field(8'd0, FLD_TGT_H, 16'sd480);
		write_field(8'd0, FLD_PRESENT, 16'sd1);
		write_field(8'd0, FLD_ENABLED, 16'h8000);
		mapped.push_back(0);
		send(OP_FWD, '0, '0, '0, 16'sd10, 16'sd20, '0, '0);
		send(OP_FWD, '0, '0, '0, 16'sd109, 16'sd69, '0, '0);
		send(OP_FWD, '0, '0, '0, 16'sd110, 16'sd69, '0, '0);
		send(OP_INV, '0, '0, '0, 16'sd50, 16'sd30, 16'sd0, 16'sd0);
		send(OP_INV, '0, '0, '0, 16'sd50, 16'sd30, 16'h8000, 16'h7fff);
		send(OP_INV, '0, '0, '0, 16'sd50, 16'sd30, 16'h7fff, 16'h8000);
		send(2'd3, 8'hff, 3'd7, 16'hffff, 16'sd50, 16'sd30, 16'hffff, 16'hffff);
		write_field(8'd255, FLD_ORG_X, 16'h8000);
		write_field(8'd255, FLD_ORG_X, 16'h7fff);
		write_field(8'd255, FLD_PRESENT, 16'hffff);
		send(OP_FWD, '0, '0, '0, 16'h8000, 16'h7fff, '0, '0);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 8) configure(limits[ph], counts[ph]);
			else configure(10'($urandom), 10'($urandom));
			no_idle = (ph == 4);
			if (ph == 2) hold_req = 1'b1;
			while (sent < 25 + (ph + 1) * 205) begin
				r = $urandom_range(0, 99);
				if (r < 22) program_entry(($urandom_range(0, 9) == 0) ?
					8'($urandom_range(200, 255)) : 8'($urandom_range(0, 40)),
					$urandom_range(0, 7) == 0);
				else if (r < 30) write_field(8'($urandom), 3'($urandom), rnd16());
				else if (r < 32) send(2'd3, 8'($urandom), 3'($urandom), rnd16(), rnd16(),
					rnd16(), rnd16(), rnd16());
				else lookup(($urandom_range(0, 1) == 0) ? OP_FWD : OP_INV,
					$urandom_range(0, 99) < 75);
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
